FILE: hw/rtl/bbp_pkg.sv
// Shared types and constants for the bimodal two-bit branch predictor.
// No dependencies; bbp_ctrl, bbp_dp and the top level in hw/rtl use this package.
`timescale 1ns / 1ps

package bbp_pkg;

  // Default table geometry, handed to the top-level parameters.
  localparam int TABLE_ENTRIES_DEF = 1024;
  localparam int INDEX_BITS_DEF    = 10;

  // Field widths.
  localparam int ADDR_W      = 64;
  localparam int COUNT_W     = 32;
  localparam int IN_TDATA_W  = 72;  // 64 + 1 bits rounded up to whole bytes
  localparam int OUT_TDATA_W = 72;  // 1 + 1 + 32 + 32 bits rounded up to whole bytes

  // Two-bit saturating counter encoding.
  typedef logic [1:0] ctr_t;
  localparam ctr_t CTR_STRONG_NT = 2'd0;
  localparam ctr_t CTR_WEAK_NT   = 2'd1;
  localparam ctr_t CTR_STRONG_T  = 2'd3;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MOD,
    ST_READ,
    ST_UPDATE
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_wr;    // write the reset value at the sweep address and advance
    logic capture;   // latch the incoming branch
    logic mod_step;  // one step of the index reduction
    logic rd_en;     // read the selected counter
    logic update;    // write back the counter and load the result
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;  // sweep is at the last table entry
    logic mod_last;  // index reduction is at its last step
    logic out_free;  // result register can take a new result this cycle
  } sts_t;

endpackage

FILE: hw/rtl/bimodal_two_bit_branch_predictor_core.sv
// Top level of the bimodal two-bit branch predictor; uses bbp_pkg, bbp_ctrl and bbp_dp.
// Each branch goes through the capture, read and write-back steps of the controller, with
// the two-step reciprocal index remainder after the capture when the table is smaller
// than 2^INDEX_BITS. Write-back waits while an earlier result has not gone out, and a new
// branch is taken only after write-back. Reset: synchronous, active low; a clearing pass
// over every table entry sets every counter to weakly-not-taken before any input is taken.
`timescale 1ns / 1ps

module bimodal_two_bit_branch_predictor_core #(
  parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_BITS    = bbp_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  // Resolved-branch channel.
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // [63:0] branch_address, [64] actual_taken, [71:65] zero.
  input  logic [bbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  // Prediction result channel.
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] predicted_taken, [1] mispredicted, [33:2] prediction_count,
  // [65:34] misprediction_count, [71:66] zero.
  output logic [bbp_pkg::OUT_TDATA_W-1:0] out_tdata
);

  import bbp_pkg::*;

  // The controller sequences each branch: it takes the input transfer, runs
  // the index remainder when the table is smaller than the index range,
  // reads the counter, and writes it back while loading the result register.
  // The result register lets the block take the next branch while a result
  // still waits for its transfer; the write-back of the following branch
  // waits only if that result has not yet gone out.
  cmd_t cmd;
  sts_t sts;

  bbp_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .INDEX_BITS    (INDEX_BITS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  // The datapath holds the counter table, the index reduction, the
  // saturating prediction and misprediction counts, and the result register.
  bbp_dp #(
    .TABLE_ENTRIES (TABLE_ENTRIES),
    .INDEX_BITS    (INDEX_BITS)
  ) u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

FILE: hw/rtl/bbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

FILE: hw/rtl/bbp_ctrl.sv
// Controller state machine of the branch predictor: clearing sweep, input
// transfer, index reduction, counter read and write-back. Uses bbp_pkg.
`timescale 1ns / 1ps

module bbp_ctrl #(
  parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_BITS    = bbp_pkg::INDEX_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  bbp_pkg::sts_t sts,
  output bbp_pkg::cmd_t cmd
);

  import bbp_pkg::*;

  // The index needs reducing only when the table is smaller than the index range.
  localparam bit NEED_MOD = (TABLE_ENTRIES < (1 << INDEX_BITS));

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (sts.clr_last) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = NEED_MOD ? ST_MOD : ST_READ;
        end
      end
      ST_MOD: begin
        if (sts.mod_last) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (sts.out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cmd.clr_wr = 1'b1;
      end
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
      end
      ST_MOD: begin
        cmd.mod_step = 1'b1;
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
      end
      ST_UPDATE: begin
        cmd.update = sts.out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

FILE: hw/rtl/bbp_dp.sv
// Datapath of the branch predictor: index reduction, counter table, counter
// update, running counts and the result register. Uses bbp_pkg and bbp_ram.
`timescale 1ns / 1ps

module bbp_dp #(
  parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_BITS    = bbp_pkg::INDEX_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [bbp_pkg::IN_TDATA_W-1:0]   in_tdata,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  output logic [bbp_pkg::OUT_TDATA_W-1:0]  out_tdata,
  input  bbp_pkg::cmd_t                    cmd,
  output bbp_pkg::sts_t                    sts
);

  import bbp_pkg::*;

  localparam int  IDX_W    = $clog2(TABLE_ENTRIES);
  localparam bit  NEED_MOD = (TABLE_ENTRIES < (1 << INDEX_BITS));
  localparam logic [IDX_W-1:0] LAST_ENTRY = IDX_W'(TABLE_ENTRIES - 1);

  logic [IDX_W-1:0]      clr_addr_r;
  logic [INDEX_BITS-1:0] idx_raw_r;
  logic [IDX_W-1:0]      idx;
  logic                  taken_r;
  logic                  out_valid_r;
  logic                  pred_r;
  logic                  miss_r;
  logic [COUNT_W-1:0]    pred_cnt_r;
  logic [COUNT_W-1:0]    miss_cnt_r;

  ctr_t                  ctr_rd;
  ctr_t                  ctr_nxt;
  logic                  pred;
  logic                  miss;
  logic                  ram_wr_en;
  logic [IDX_W-1:0]      ram_wr_addr;
  ctr_t                  ram_wr_data;

  // Clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
    end else if (cmd.clr_wr && (clr_addr_r != LAST_ENTRY)) begin
      clr_addr_r <= clr_addr_r + 1'b1;
    end
  end

  // Captured branch.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      idx_raw_r <= in_tdata[INDEX_BITS-1:0];
      taken_r   <= in_tdata[ADDR_W];
    end
  end

  generate
    if (NEED_MOD) begin : g_mod
      // Reciprocal of the table size scaled by 2^INDEX_BITS. The estimated quotient is
      // at most one below the true one, so one compare and subtract ends the remainder.
      localparam int MUL_W = 2 * INDEX_BITS;
      localparam logic [INDEX_BITS-1:0] RECIP   =
        INDEX_BITS'((1 << INDEX_BITS) / TABLE_ENTRIES);
      localparam logic [INDEX_BITS-1:0] ENTRIES = INDEX_BITS'(TABLE_ENTRIES);

      logic [IDX_W-1:0]      rem_r;
      logic [INDEX_BITS-1:0] quot_r;
      logic                  step_r;
      logic [MUL_W-1:0]      prod;
      logic [INDEX_BITS-1:0] quot_n;
      logic [INDEX_BITS-1:0] rem_est;

      // First step estimates the quotient, second step forms the remainder.
      assign prod    = MUL_W'(idx_raw_r) * MUL_W'(RECIP);
      assign quot_n  = quot_r * ENTRIES;
      assign rem_est = idx_raw_r - quot_n;

      always_ff @(posedge clk) begin
        if (cmd.capture) begin
          step_r <= 1'b0;
        end else if (cmd.mod_step) begin
          if (!step_r) begin
            quot_r <= prod[MUL_W-1:INDEX_BITS];
          end else begin
            rem_r <= (rem_est >= ENTRIES) ? IDX_W'(rem_est - ENTRIES) : IDX_W'(rem_est);
          end
          step_r <= 1'b1;
        end
      end

      assign idx          = rem_r;
      assign sts.mod_last = step_r;
    end else begin : g_nomod
      assign idx          = IDX_W'(idx_raw_r);
      assign sts.mod_last = 1'b1;
    end
  endgenerate

  // Counter table; the sweep and the write-back share the write port.
  assign ram_wr_en   = cmd.clr_wr | cmd.update;
  assign ram_wr_addr = cmd.clr_wr ? clr_addr_r : idx;
  assign ram_wr_data = cmd.clr_wr ? CTR_WEAK_NT : ctr_nxt;

  bbp_ram #(
    .WIDTH ($bits(ctr_t)),
    .DEPTH (TABLE_ENTRIES)
  ) u_table (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_en),
    .rd_addr (idx),
    .rd_data (ctr_rd)
  );

  // Prediction and saturating counter step.
  assign pred = ctr_rd[1];
  assign miss = pred ^ taken_r;

  always_comb begin
    ctr_nxt = ctr_rd;
    if (taken_r) begin
      if (ctr_rd != CTR_STRONG_T) begin
        ctr_nxt = ctr_rd + 1'b1;
      end
    end else begin
      if (ctr_rd != CTR_STRONG_NT) begin
        ctr_nxt = ctr_rd - 1'b1;
      end
    end
  end

  // Running counts double as the count fields of the result register; they
  // change only when the result slot is free.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pred_cnt_r <= '0;
      miss_cnt_r <= '0;
    end else if (cmd.update) begin
      if (!(&pred_cnt_r)) begin
        pred_cnt_r <= pred_cnt_r + 1'b1;
      end
      if (miss && !(&miss_cnt_r)) begin
        miss_cnt_r <= miss_cnt_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.update) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.update) begin
      pred_r <= pred;
      miss_r <= miss;
    end
  end

  assign sts.clr_last = (clr_addr_r == LAST_ENTRY);
  assign sts.out_free = !out_valid_r || out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - 2 - 2 * COUNT_W){1'b0}},
                       miss_cnt_r, pred_cnt_r, miss_r, pred_r};

endmodule

FILE: test/bbp_scoreboard.sv
// Checker for the bimodal two-bit branch predictor: watches both streams, keeps its own
// copy of the counter table and the running counts, and compares every result transfer.
// Depends on bbp_pkg for field widths and the counter encoding.
`timescale 1ns / 1ps

module bbp_scoreboard #(
  parameter int TABLE_ENTRIES = bbp_pkg::TABLE_ENTRIES_DEF,
  parameter int INDEX_BITS    = bbp_pkg::INDEX_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  input  logic                            in_tready,
  // [63:0] branch_address, [64] actual_taken, [71:65] zero.
  input  logic [bbp_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic                            out_tvalid,
  input  logic                            out_tready,
  // [0] predicted_taken, [1] mispredicted, [33:2] prediction_count,
  // [65:34] misprediction_count, [71:66] zero.
  input  logic [bbp_pkg::OUT_TDATA_W-1:0] out_tdata,
  output int                              fail_cnt,
  output int                              pending_cnt
);
  import bbp_pkg::*;

  typedef struct packed {
    logic               taken_pred;
    logic               miss;
    logic [COUNT_W-1:0] n_pred;
    logic [COUNT_W-1:0] n_miss;
  } branch_outcome_t;

  ctr_t               ctr_mirror [TABLE_ENTRIES];
  logic [COUNT_W-1:0] pred_total;
  logic [COUNT_W-1:0] miss_total;
  branch_outcome_t    outcome_q[$];

  initial begin
    fail_cnt    = 0;
    pending_cnt = 0;
  end

  // Looks up the counter, forms the prediction, and steps the mirrored state.
  function automatic branch_outcome_t predict_branch(logic [ADDR_W-1:0] addr, logic taken);
    branch_outcome_t res;
    int unsigned     idx;
    ctr_t            ctr;
    idx = int'(addr[INDEX_BITS-1:0]) % TABLE_ENTRIES;
    ctr = ctr_mirror[idx];
    res.taken_pred = ctr[1];
    res.miss       = ctr[1] ^ taken;
    if (taken) begin
      if (ctr != CTR_STRONG_T) ctr = ctr + 2'd1;
    end else begin
      if (ctr != CTR_STRONG_NT) ctr = ctr - 2'd1;
    end
    ctr_mirror[idx] = ctr;
    if (pred_total != '1) pred_total = pred_total + 1'b1;
    if (res.miss && miss_total != '1) miss_total = miss_total + 1'b1;
    res.n_pred = pred_total;
    res.n_miss = miss_total;
    return res;
  endfunction

  task automatic check_field(string fname, logic [COUNT_W-1:0] exp_v, logic [COUNT_W-1:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, fname, exp_v, act_v);
      fail_cnt++;
    end
  endtask

  always @(posedge clk) begin
    branch_outcome_t exp_r;
    if (!rst_n) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) ctr_mirror[i] = CTR_WEAK_NT;
      pred_total = '0;
      miss_total = '0;
      outcome_q.delete();
      pending_cnt <= 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result transfer, expected none, actual %0h",
                   $realtime, out_tdata);
          fail_cnt++;
        end else begin
          exp_r = outcome_q.pop_front();
          check_field("predicted_taken", COUNT_W'(exp_r.taken_pred), COUNT_W'(out_tdata[0]));
          check_field("mispredicted", COUNT_W'(exp_r.miss), COUNT_W'(out_tdata[1]));
          check_field("prediction_count", exp_r.n_pred, out_tdata[33:2]);
          check_field("misprediction_count", exp_r.n_miss, out_tdata[65:34]);
        end
      end
      if (in_tvalid && in_tready)
        outcome_q.push_back(predict_branch(in_tdata[ADDR_W-1:0], in_tdata[ADDR_W]));
      pending_cnt <= outcome_q.size();
    end
  end

endmodule

FILE: test/bimodal_two_bit_branch_predictor_core_tb.sv
// Testbench top for the bimodal two-bit branch predictor: clock, reset, branch stimulus,
// result-side back-pressure, watchdog and verdict. Uses bbp_pkg, bbp_scoreboard and the core.
`timescale 1ns / 1ps

module bimodal_two_bit_branch_predictor_core_tb;
  import bbp_pkg::*;

  localparam int IDX_W     = INDEX_BITS_DEF;
  // Cycles with no transfer on either side before the run is declared hung. The clearing
  // pass after reset and the longest idle stretch both stay well below this limit.
  localparam int HANG_LIMIT = 6000;

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  int fail_cnt;
  int pending_cnt;

  // When cleared, the matching side runs without any idle cycles.
  bit src_idle_en  = 1'b1;
  bit sink_stall_en = 1'b1;

  // Hot table entries with a per-entry taken bias, so counters reach both strong states.
  logic [IDX_W-1:0] hot_idx [8];
  int               hot_bias [8] = '{97, 90, 75, 50, 25, 10, 3, 60};

  bimodal_two_bit_branch_predictor_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  bbp_scoreboard checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .fail_cnt   (fail_cnt),
    .pending_cnt(pending_cnt)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int pick_idle();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Result-side back-pressure. Ready is held for runs of random length; while stalls are
  // disabled it stays high so the block can run at its full rate.
  int ready_hold = 0;
  always @(posedge clk) begin
    int r;
    if (!sink_stall_en) begin
      out_tready <= 1'b1;
      ready_hold <= 0;
    end else if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 50) begin
        out_tready <= 1'b1;
        ready_hold <= $urandom_range(0, 40);
      end else if (r < 85) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(0, 2);
      end else if (r < 97) begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(3, 11);
      end else begin
        out_tready <= 1'b0;
        ready_hold <= $urandom_range(30, 80);
      end
    end
  end

  // Watchdog: any transfer on either side restarts the count.
  int quiet_cycles = 0;
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= HANG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offers one resolved branch and returns at the edge where it is transferred. Valid stays
  // high on return, so a following branch is offered without a gap.
  task automatic send_branch(logic [ADDR_W-1:0] addr, logic taken);
    int gap;
    gap = src_idle_en ? pick_idle() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {7'd0, taken, addr};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Most random branches hit a hot entry, with random upper address bits to show that only
  // the index bits matter; the rest are fully random addresses and outcomes.
  task automatic send_random_branch();
    logic [ADDR_W-1:0] addr;
    int                k;
    addr = {$urandom, $urandom};
    if ($urandom_range(0, 99) < 70) begin
      k = $urandom_range(0, 7);
      addr[IDX_W-1:0] = hot_idx[k];
      send_branch(addr, $urandom_range(0, 99) < hot_bias[k]);
    end else begin
      send_branch(addr, 1'($urandom_range(0, 1)));
    end
  endtask

  // Lowers valid and waits until every predicted result has been transferred. The first
  // edge lets the checker account for a branch transferred at the current edge.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_cnt != 0) @(posedge clk);
  endtask

  initial begin
    hot_idx[0] = '0;
    hot_idx[1] = '1;
    for (int k = 2; k < 8; k++) hot_idx[k] = IDX_W'($urandom_range(0, (1 << IDX_W) - 1));

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part. Address extremes and alternating patterns first.
    send_branch(64'h0000_0000_0000_0000, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_branch(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_branch(64'h5555_5555_5555_5555, 1'b0);
    // Drive one entry up into strongly taken and keep it there with further taken branches.
    send_branch(64'h0000_0000_0000_0123, 1'b1);
    send_branch(64'h0000_0000_0000_0123, 1'b1);
    send_branch(64'h0000_0000_0000_0123, 1'b1);
    send_branch(64'h0000_0000_0000_0123, 1'b1);
    // A not-taken branch from the strong state is a misprediction; then walk down to
    // strongly not taken and stay there.
    send_branch(64'h0000_0000_0000_0123, 1'b0);
    send_branch(64'h0000_0000_0000_0123, 1'b0);
    send_branch(64'h0000_0000_0000_0123, 1'b0);
    send_branch(64'h0000_0000_0000_0123, 1'b0);
    send_branch(64'h0000_0000_0000_0123, 1'b0);
    send_branch(64'h0000_0000_0000_0123, 1'b1);
    // Addresses that differ only above the index bits share one counter.
    send_branch(64'h0000_0000_0000_0400, 1'b1);
    send_branch(64'h8000_0000_0000_0000, 1'b1);
    send_branch(64'h1234_5678_9ABC_DC00, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_FC00, 1'b1);
    // Highest table entry, reached from different upper bits.
    send_branch(64'h0000_0000_0000_03FF, 1'b0);
    send_branch(64'hFFFF_FFFF_FFFF_FBFF, 1'b0);
    send_branch(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);

    // Random part with idling on both sides.
    repeat (900) send_random_branch();

    // Sender holds off until everything in flight has come back.
    drain_results();

    // Back-to-back branches with the result side always ready.
    src_idle_en   = 1'b0;
    sink_stall_en = 1'b0;
    repeat (300) send_random_branch();
    src_idle_en   = 1'b1;
    sink_stall_en = 1'b1;

    repeat (650) send_random_branch();

    // Final drain, then a few cycles for anything the block should not send.
    drain_results();
    repeat (10) @(posedge clk);

    if (fail_cnt == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

FILE: files.f
hw/rtl/bbp_pkg.sv
hw/rtl/bbp_ram.sv
hw/rtl/bbp_ctrl.sv
hw/rtl/bbp_dp.sv
hw/rtl/bimodal_two_bit_branch_predictor_core.sv
test/bbp_scoreboard.sv
test/bimodal_two_bit_branch_predictor_core_tb.sv
